>>> hdl/snr_crossing_activity_monitor_top_macros.svh
// ----------------------------------------------------------------------------
// SNR crossing activity monitor assertion macros
// Shorthand for clocked concurrent checks, gated by reset.
// ----------------------------------------------------------------------------
`ifndef SNR_CROSSING_ACTIVITY_MONITOR_TOP_MACROS_SVH
`define SNR_CROSSING_ACTIVITY_MONITOR_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define SCAM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SCAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/scam_pkg.sv
// ----------------------------------------------------------------------------
// SNR crossing activity monitor package
// Item types, station table row, codes and crossing helper.
// ----------------------------------------------------------------------------
package scam_pkg;

    localparam int unsigned MS_PER_SEC = 1000;
    localparam int unsigned MS_W       = 26;   // 65535 s in ms fits in 26 bits
    localparam int unsigned CFG_AW     = 3;
    localparam int unsigned CFG_DW     = 32;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SNR_HIGH     = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SNR_LOW      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SNR_INACTIVE = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SAMPLE_SEC   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_WINDOW_SEC   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_PKT_THRESH   = 3'd5;

    // Request types
    localparam logic REQ_POLL  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Threshold change codes
    localparam logic [1:0] CHG_NONE = 2'd0;
    localparam logic [1:0] CHG_UP   = 2'd1;
    localparam logic [1:0] CHG_DOWN = 2'd2;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_INACTIVE = 2'd1,
        ACT_ACTIVE   = 2'd2
    } t_activity;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         station_index;
        logic signed [7:0]  current_snr;
        logic               snr_valid;
        logic [31:0]        tx_count;
        logic [31:0]        rx_count;
        logic [31:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [5:0] out_station;
        logic       snr_event;
        logic [1:0] high_change;
        logic [1:0] low_change;
        logic [1:0] inactive_change;
        logic [7:0] snr_magnitude;
        logic       activity_event;
        logic       station_active;
    } t_out_item;

    // One station table entry
    typedef struct packed {
        logic signed [7:0] last_snr;
        logic              prev_valid;
        logic [31:0]       acc;
        logic [31:0]       last_sample;
        logic [31:0]       win_start;
        t_activity         state;
    } t_row;

    localparam t_row ROW_RESET = '{
        last_snr:    8'sd0,
        prev_valid:  1'b0,
        acc:         32'd0,
        last_sample: 32'd0,
        win_start:   32'd0,
        state:       ACT_START
    };

    // Classify the move of the SNR across one level.
    function automatic logic [1:0] snr_cross(
        input logic              both_valid,
        input logic signed [7:0] before_snr,
        input logic signed [7:0] now_snr,
        input logic signed [7:0] level
    );
        logic [1:0] code;
        code = CHG_NONE;
        if (both_valid) begin
            if (before_snr <= level && now_snr > level) begin
                code = CHG_UP;
            end else if (before_snr > level && now_snr <= level) begin
                code = CHG_DOWN;
            end
        end
        return code;
    endfunction

endpackage

>>> hdl/snr_crossing_activity_monitor_top.sv
// ----------------------------------------------------------------------------
// SNR crossing activity monitor
// Per-station SNR threshold crossing and packet activity tracker.
//
// Each item is a poll or a clear for one station. A poll reports how the
// SNR moved across the high, low and inactive levels since the previous
// poll, folds tx plus rx packets into a saturating per-station count once
// the sample interval has passed, and decides active or inactive when the
// check window has run out. Every item gives exactly one result item.
// The block takes one item per clock cycle while i_out_ready does not hold
// back the result register. Accepting an item registers it in stage A and
// reads the station table; stage A then computes, and when it fires it
// writes the entry back and loads the result register. The table is one
// memory with one write and one read port; a
// poll that follows a poll of the same station takes the freshly computed
// entry through a forwarding register, so back-to-back items on one station
// cost nothing extra. Table entries read as their reset value until first
// written, tracked by one flip-flop per station, so no clearing pass runs
// after reset. Stations at or beyond STATION_COUNT get zeros but out_station.
// Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
`include "snr_crossing_activity_monitor_top_macros.svh"

module snr_crossing_activity_monitor_top
    import scam_pkg::*;
#(
    parameter int unsigned STATION_COUNT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item
);

    localparam int unsigned AW = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;

    // ------------------------------------------------------------------
    // Configuration registers; intervals are kept in milliseconds
    // ------------------------------------------------------------------
    logic signed [7:0] r_snr_high;
    logic signed [7:0] r_snr_low;
    logic signed [7:0] r_snr_inactive;
    logic [MS_W-1:0]   r_sample_ms;
    logic [MS_W-1:0]   r_window_ms;
    logic [31:0]       r_pkt_thresh;
    logic [MS_W-1:0]   cfg_ms;

    assign cfg_ms = MS_W'(i_cfg_wdata[15:0]) * MS_W'(MS_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snr_high     <= 8'sd0;
            r_snr_low      <= 8'sd0;
            r_snr_inactive <= 8'sd0;
            r_sample_ms    <= MS_W'(MS_PER_SEC);
            r_window_ms    <= MS_W'(10 * MS_PER_SEC);
            r_pkt_thresh   <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SNR_HIGH:     r_snr_high     <= i_cfg_wdata[7:0];
                CFG_SNR_LOW:      r_snr_low      <= i_cfg_wdata[7:0];
                CFG_SNR_INACTIVE: r_snr_inactive <= i_cfg_wdata[7:0];
                CFG_SAMPLE_SEC:   r_sample_ms    <= cfg_ms;
                CFG_WINDOW_SEC:   r_window_ms    <= cfg_ms;
                CFG_PKT_THRESH:   r_pkt_thresh   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: stage A holds the item under work, stage O the result
    // ------------------------------------------------------------------
    logic r_a_valid;
    logic r_o_valid;
    logic adv;      // result register free or being emptied
    logic a_fire;   // stage A item finishes this cycle
    logic in_acc;   // new item taken this cycle

    assign adv        = !r_o_valid || i_out_ready;
    assign a_fire     = r_a_valid && adv;
    assign o_in_ready = !r_a_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_out_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: register the item, pre-add the packet counts
    // ------------------------------------------------------------------
    t_in_item    r_a;
    logic [31:0] r_a_pkt;
    logic [32:0] pkt_sum;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] a_addr;
    logic          a_in_range;

    assign pkt_sum    = {1'b0, i_in_item.tx_count} + {1'b0, i_in_item.rx_count};
    assign in_addr    = AW'(i_in_item.station_index);
    assign a_addr     = AW'(r_a.station_index);
    assign a_in_range = 32'(r_a.station_index) < 32'(STATION_COUNT);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a     <= i_in_item;
            r_a_pkt <= pkt_sum[32] ? 32'hFFFF_FFFF : pkt_sum[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Station table: registered read on accept, write when stage A fires
    // ------------------------------------------------------------------
    t_row               r_mem [STATION_COUNT];
    t_row               r_rd_row;
    logic [STATION_COUNT-1:0] r_touched;
    logic               r_rd_touched;
    logic               r_fwd;
    t_row               r_fwd_row;
    t_row               row;
    t_row               n_row;
    logic               a_write;
    logic               fwd;

    assign a_write = a_fire && a_in_range;
    assign fwd     = a_write && (r_a.station_index == i_in_item.station_index);

    always_ff @(posedge i_clk) begin
        if (a_write) begin
            r_mem[a_addr] <= n_row;
        end
        if (in_acc) begin
            r_rd_row <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched    <= '0;
            r_rd_touched <= 1'b0;
            r_fwd        <= 1'b0;
        end else begin
            if (a_write) begin
                r_touched[a_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_rd_touched <= r_touched[in_addr];
                r_fwd        <= fwd;
            end
        end
    end

    // Hold the entry just computed for an immediate repeat of the station
    always_ff @(posedge i_clk) begin
        if (in_acc && fwd) begin
            r_fwd_row <= n_row;
        end
    end

    always_comb begin
        if (r_fwd) begin
            row = r_fwd_row;
        end else if (r_rd_touched) begin
            row = r_rd_row;
        end else begin
            row = ROW_RESET;
        end
    end

    // ------------------------------------------------------------------
    // Stage A compute: crossings, packet sampling, activity decision
    // ------------------------------------------------------------------
    logic        both_valid;
    logic [1:0]  hc;
    logic [1:0]  lc;
    logic [1:0]  ic;
    logic [31:0] samp_age;
    logic [31:0] win_age;
    logic        samp_due;
    logic        win_due;
    logic [32:0] acc_sum;
    logic [31:0] acc_s;
    logic        busy;
    t_activity   n_state;
    logic        act_ev;
    logic        act_val;
    logic [7:0]  snr_mag;
    t_out_item   n_out;

    assign both_valid = r_a.snr_valid && row.prev_valid;
    assign hc = snr_cross(both_valid, row.last_snr, r_a.current_snr, r_snr_high);
    assign lc = snr_cross(both_valid, row.last_snr, r_a.current_snr, r_snr_low);
    assign ic = snr_cross(both_valid, row.last_snr, r_a.current_snr, r_snr_inactive);

    // Wrapping age compared against the interval
    assign samp_age = r_a.now_ms - row.last_sample;
    assign win_age  = r_a.now_ms - row.win_start;
    assign samp_due = samp_age > 32'(r_sample_ms);
    assign win_due  = win_age > 32'(r_window_ms);

    assign acc_sum = {1'b0, row.acc} + {1'b0, r_a_pkt};
    assign acc_s   = !samp_due  ? row.acc :
                     acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    assign busy    = acc_s > r_pkt_thresh;

    // -128 negates to 8'h80, which reads as 128 unsigned
    assign snr_mag = r_a.current_snr[7] ? 8'(-r_a.current_snr) : r_a.current_snr;

    always_comb begin
        n_state = row.state;
        act_ev  = 1'b0;
        act_val = 1'b0;
        if (win_due) begin
            case (row.state)
                ACT_START: begin
                    n_state = busy ? ACT_ACTIVE : ACT_INACTIVE;
                    act_ev  = 1'b1;
                    act_val = busy;
                end
                ACT_INACTIVE: begin
                    if (busy) begin
                        n_state = ACT_ACTIVE;
                        act_ev  = 1'b1;
                        act_val = 1'b1;
                    end
                end
                ACT_ACTIVE: begin
                    if (!busy) begin
                        n_state = ACT_INACTIVE;
                        act_ev  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_row = row;
        if (r_a.req_type == REQ_CLEAR) begin
            // drop activity decision and SNR history; keep counts and times
            n_row.state      = ACT_START;
            n_row.prev_valid = 1'b0;
        end else begin
            n_row.last_snr    = r_a.current_snr;
            n_row.prev_valid  = r_a.snr_valid;
            n_row.acc         = win_due ? 32'd0 : acc_s;
            n_row.last_sample = samp_due ? r_a.now_ms : row.last_sample;
            n_row.win_start   = win_due ? r_a.now_ms : row.win_start;
            n_row.state       = n_state;
        end
    end

    always_comb begin
        n_out = '0;
        n_out.out_station = r_a.station_index;
        if (a_in_range && r_a.req_type == REQ_POLL) begin
            n_out.snr_event       = (hc != CHG_NONE) || (lc != CHG_NONE) || (ic != CHG_NONE);
            n_out.high_change     = hc;
            n_out.low_change      = lc;
            n_out.inactive_change = ic;
            n_out.snr_magnitude   = snr_mag;
            n_out.activity_event  = act_ev;
            n_out.station_active  = act_val;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic out_on;
    logic out_any_chg;
    logic clr_fire;
    logic out_quiet;

    assign out_on      = o_out_valid && o_out_item.station_active;
    assign out_any_chg = (o_out_item.high_change != CHG_NONE)
                      || (o_out_item.low_change != CHG_NONE)
                      || (o_out_item.inactive_change != CHG_NONE);
    assign clr_fire    = a_fire && (r_a.req_type == REQ_CLEAR);
    assign out_quiet   = !o_out_item.snr_event && !o_out_item.activity_event
                      && (o_out_item.snr_magnitude == 8'd0);

    `SCAM_ASSERT_SAME(a_active_has_event, out_on, o_out_item.activity_event, "active w/o event")
    `SCAM_ASSERT_SAME(a_snr_event_match, o_out_valid, o_out_item.snr_event == out_any_chg, "bad snr_event")
    `SCAM_ASSERT_NEXT(a_clear_quiet, clr_fire, out_quiet, "clear result carries data")
    `SCAM_ASSERT_NEXT(a_write_marks_entry, a_write, r_touched[$past(a_addr)], "entry not marked")

endmodule
